// ===== design/ilds_pkg.sv =====
`default_nettype none
package ilds_pkg;

  localparam int MODE_W   = 1;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int SUM_W    = 38;

  localparam logic [MODE_W-1:0] MODE_APPEND = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage
`default_nettype wire

// ===== design/ilds_if.sv =====
`default_nettype none
interface ilds_in_if import ilds_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface ilds_out_if import ilds_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [TOTAL_W-1:0]        entry_total;
  logic signed [SUM_W-1:0]   value_sum;
  logic signed [VALUE_W-1:0] largest;
  logic signed [VALUE_W-1:0] smallest;
  logic                      is_empty;

  modport source (output valid, status, entry_total, value_sum, largest, smallest, is_empty,
                  input ready);
  modport sink   (input valid, status, entry_total, value_sum, largest, smallest, is_empty,
                  output ready);
endinterface
`default_nettype wire

// ===== design/integer_list_delete_stats.sv =====
`default_nettype none
// Channel   Dir  Modport  Payload
// in_chan   in   sink     mode, value
// out_chan  out  source   status, entry_total, value_sum, largest, smallest, is_empty
//
// An accepted item moves to S_SCAN, which reads each entry (entry_count after an
// append, before a delete), then to S_DONE, which registers the result once the
// output is free. One pass over the list RAM, one read per cycle, does the delete
// search, the shift-down write back and the statistics.
// rst_n (sync, active low) empties the list; RAM contents are not cleared.
// in_ready is high while idle, also when an earlier result still waits on out_ready.
module integer_list_delete_stats import ilds_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ilds_in_if.sink   in_chan,
  ilds_out_if.source out_chan
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [CW-1:0] count_r;     // entries held
  logic [CW-1:0] iss_r;       // next index to read
  logic          rd_vld_r;    // RAM data valid this cycle
  logic [AW-1:0] rd_idx_r;    // index of that data
  logic          found_r;     // delete match seen
  logic          have_r;      // at least one entry folded into stats
  logic [MODE_W-1:0]  mode_r;
  logic [VALUE_W-1:0] value_r;
  logic [STATUS_W-1:0] status_r;
  logic [SUM_W-1:0]   sum_r;
  logic signed [VALUE_W-1:0] hi_r, lo_r;

  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [VALUE_W-1:0] out_hi_r, out_lo_r;
  logic               out_empty_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [VALUE_W-1:0] ram_rdata;

  logic accept, full, scan_end, match, out_free;
  logic signed [VALUE_W-1:0] rd_s;
  logic [CW-1:0] final_count;

  assign accept   = in_chan.valid && in_chan.ready;
  assign full     = (count_r >= CW'(CAPACITY));
  assign ram_re   = (state_r == S_SCAN) && (iss_r < count_r);
  assign scan_end = (state_r == S_SCAN) && (iss_r >= count_r) && !rd_vld_r;
  assign rd_s     = $signed(ram_rdata);
  // first entry equal to the delete value is dropped, not counted
  assign match    = rd_vld_r && !found_r && (mode_r == MODE_DELETE) && (ram_rdata == value_r);
  assign out_free = !out_valid_r || out_chan.ready;
  assign final_count = found_r ? (count_r - CW'(1)) : count_r;

  assign in_chan.ready = (state_r == S_IDLE);

  // Write port: append at the tail on accept, or shift an entry down one slot
  // behind a delete match. The read runs ahead of the write, so no overlap.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = in_chan.value;
    if (accept) begin
      ram_we = (in_chan.mode == MODE_APPEND) && !full;
    end else if (rd_vld_r && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_r - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  ilds_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (ram_re) begin
        iss_r <= iss_r + CW'(1);
      end
      if (accept) begin
        iss_r   <= '0;
        found_r <= 1'b0;
        have_r  <= 1'b0;
        if ((in_chan.mode == MODE_APPEND) && !full) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (match) begin
        found_r <= 1'b1;
      end else if (rd_vld_r) begin
        have_r <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        count_r     <= final_count;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx_r <= iss_r[AW-1:0];
    if (accept) begin
      mode_r   <= in_chan.mode;
      value_r  <= in_chan.value;
      status_r <= ((in_chan.mode == MODE_APPEND) && full) ? ST_FULL : ST_DONE;
      sum_r    <= '0;
    end else if (rd_vld_r && !match) begin
      sum_r <= sum_r + {{(SUM_W-VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};
      if (!have_r || rd_s > hi_r) hi_r <= rd_s;
      if (!have_r || rd_s < lo_r) lo_r <= rd_s;
    end
    if (state_r == S_DONE && out_free) begin
      if (mode_r == MODE_DELETE) begin
        out_status_r <= found_r ? ST_DONE : ST_NOT_FOUND;
      end else begin
        out_status_r <= status_r;
      end
      out_total_r <= TOTAL_W'(final_count);
      out_sum_r   <= sum_r;
      out_hi_r    <= have_r ? hi_r : '0;
      out_lo_r    <= have_r ? lo_r : '0;
      out_empty_r <= (final_count == '0);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_total = out_total_r;
  assign out_chan.value_sum   = out_sum_r;
  assign out_chan.largest     = out_hi_r;
  assign out_chan.smallest    = out_lo_r;
  assign out_chan.is_empty    = out_empty_r;

endmodule
`default_nettype wire

// ===== design/ilds_ram.sv =====
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle.
module ilds_ram import ilds_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [VALUE_W-1:0]  wdata,
  input  wire logic                re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [VALUE_W-1:0]  rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
